// ===== sv/lde_pkg.sv =====
// Shared constants, codes and fixed-point helpers of the Lorentz cell update.
`timescale 1ns / 1ps
package lde_pkg;

  // Default grid size
  localparam int GRID_X_DEF = 256;
  localparam int GRID_Z_DEF = 512;

  // Widths fixed by the item and register formats
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 2;
  localparam int CX_W     = 8;
  localparam int CZ_W     = 9;
  localparam int CFG_IX_W = 3;
  localparam int PROD_W   = 2 * DATA_W;   // exact product
  localparam int RND_W    = PROD_W - 24;  // product rounded to Q16.24
  localparam int ACC_W    = RND_W + 3;    // sum of up to six rounded terms
  localparam int HIST_W   = 4 * DATA_W;   // F1, F2, S1, S2 of one cell

  localparam logic signed [DATA_W-1:0] ONE_Q24 = 32'sh0100_0000;

  // Field commands; the unused code is taken and dropped
  localparam logic [CMD_W-1:0] CMD_EY     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HX     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HZ     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IX_W-1:0] REG_COEF_ONE    = 3'd0;
  localparam logic [CFG_IX_W-1:0] REG_COEF_TWO    = 3'd1;
  localparam logic [CFG_IX_W-1:0] REG_COEF_THREE  = 3'd2;
  localparam logic [CFG_IX_W-1:0] REG_RECIP       = 3'd3;
  localparam logic [CFG_IX_W-1:0] REG_ELEC_SCALE  = 3'd4;
  localparam logic [CFG_IX_W-1:0] REG_MAG_SCALE   = 3'd5;
  localparam logic [CFG_IX_W-1:0] REG_SLAB_FIRST  = 3'd6;
  localparam logic [CFG_IX_W-1:0] REG_SLAB_LAST   = 3'd7;

  // Round an exact Q16.48 product to Q16.24, floor((p + 2^23) / 2^24)
  function automatic logic signed [RND_W-1:0] q_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = p + (64'sd1 <<< 23);
    return q[PROD_W-1:24];
  endfunction

  // Saturate a wide sum to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== sv/lorentz_dispersive_cell_update.sv =====
// Top level of the Lorentz dispersive cell update with its history memory.
`timescale 1ns / 1ps
// Usage
//   Commands: drive cmd_i, cell_x_i, cell_z_i and flux_i with start high; the
//   command transfers at the clock edge where start is high and busy is low.
//   A command with an unused code or a cell outside the grid is taken and dropped.
//   Results: done_o is high for exactly one cycle with field_value_o, aux_value_o
//   and inside_slab_o; the receiver cannot stall, so results are never held back.
//   Pipeline: a command passes stages A to F and then the output registers.
//   Throughput: one command per cycle unless busy is held. The four histories of a
//   cell sit in one word of a single-port-write history memory that is read,
//   updated and written back over a five-stage pipeline; a command for a cell that
//   is still in flight holds busy until that write-back lands.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at once; write
//   only while no command is in flight.
//   Reset: registers take their reset values and a clearing pass zeroes the
//   history memory, one entry a cycle, 3*GRID_X*GRID_Z entries (393216 by default);
//   busy stays high throughout, configuration writes are still taken.
module lorentz_dispersive_cell_update
  import lde_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [CMD_W-1:0]           cmd_i,
  input  logic [CX_W-1:0]            cell_x_i,
  input  logic [CZ_W-1:0]            cell_z_i,
  input  logic signed [DATA_W-1:0]   flux_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IX_W-1:0]        cfg_idx_i,
  input  logic [DATA_W-1:0]          cfg_data_i,
  output logic                       done_o,
  output logic signed [DATA_W-1:0]   field_value_o,
  output logic signed [DATA_W-1:0]   aux_value_o,
  output logic                       inside_slab_o
);

  localparam int DEPTH = 3 * GRID_X * GRID_Z;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic signed [DATA_W-1:0] coef_one_q, coef_two_q, coef_three_q, recip_q;
  logic signed [DATA_W-1:0] elec_scale_q, mag_scale_q;
  logic [CX_W-1:0]          slab_first_q, slab_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_one_q   <= '0;
      coef_two_q   <= '0;
      coef_three_q <= '0;
      recip_q      <= ONE_Q24;
      elec_scale_q <= ONE_Q24;
      mag_scale_q  <= ONE_Q24;
      slab_first_q <= '0;
      slab_last_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COEF_ONE:   coef_one_q   <= cfg_data_i;
        REG_COEF_TWO:   coef_two_q   <= cfg_data_i;
        REG_COEF_THREE: coef_three_q <= cfg_data_i;
        REG_RECIP:      recip_q      <= cfg_data_i;
        REG_ELEC_SCALE: elec_scale_q <= cfg_data_i;
        REG_MAG_SCALE:  mag_scale_q  <= cfg_data_i;
        REG_SLAB_FIRST: slab_first_q <= cfg_data_i[CX_W-1:0];
        REG_SLAB_LAST:  slab_last_q  <= cfg_data_i[CX_W-1:0];
      endcase
    end
  end

  // Pipeline control and payload registers
  logic                     clr_active_q, clr_active_d;
  logic [AW-1:0]            clr_cnt_q, clr_cnt_d;
  logic                     a_valid_q, a_valid_d;
  logic                     b_valid_q, c_valid_q, d_valid_q, e_valid_q, f_valid_q;
  logic [AW-1:0]            a_addr_q, b_addr_q, c_addr_q, d_addr_q, e_addr_q, f_addr_q;
  logic [CMD_W-1:0]         a_cmd_q, b_cmd_q;
  logic signed [DATA_W-1:0] a_flux_q, b_flux_q;
  logic                     a_in_q, b_in_q, c_in_q, d_in_q, e_in_q, f_in_q;
  logic [HIST_W-1:0]        rd_q;
  logic signed [RND_W-1:0]  c_t0_q, c_t1_q, c_t2_q, c_t3_q, c_t4_q;
  logic signed [DATA_W-1:0] c_f1_q, d_f1_q, e_f1_q, f_f1_q;
  logic signed [DATA_W-1:0] c_s1_q, d_s1_q, e_s1_q, f_s1_q;
  logic signed [DATA_W-1:0] d_num_q, e_fnew_q, f_fnew_q;
  logic signed [ACC_W-1:0]  d_sum_q, e_sum_q, f_sum_q;
  logic signed [RND_W-1:0]  f_p_q;
  logic                     done_q;
  logic signed [DATA_W-1:0] field_q, aux_q;
  logic                     inside_q;

  // Command intake: validity, slab test and entry address
  logic          accept, item_ok, load, in_slab, hazard, a_go;
  logic [AW-1:0] row_idx, addr_d;

  assign accept  = start && !busy;
  assign item_ok = (cmd_i != CMD_UNUSED) && (32'(cell_x_i) < GRID_X) &&
                   (32'(cell_z_i) < GRID_Z);
  assign load    = accept && item_ok;
  assign in_slab = (cell_x_i >= slab_first_q) && (cell_x_i <= slab_last_q);
  assign row_idx = AW'(cmd_i) * AW'(GRID_X) + AW'(cell_x_i);
  assign addr_d  = row_idx * AW'(GRID_Z) + AW'(cell_z_i);

  // Interlock: hold the read while the same entry is still in flight
  assign hazard = (b_valid_q && (b_addr_q == a_addr_q)) ||
                  (c_valid_q && (c_addr_q == a_addr_q)) ||
                  (d_valid_q && (d_addr_q == a_addr_q)) ||
                  (e_valid_q && (e_addr_q == a_addr_q)) ||
                  (f_valid_q && (f_addr_q == a_addr_q));
  assign a_go   = a_valid_q && !hazard;
  assign busy   = clr_active_q || (a_valid_q && hazard);

  always_comb begin
    a_valid_d = a_valid_q;
    if (load) begin
      a_valid_d = 1'b1;
    end else if (a_go) begin
      a_valid_d = 1'b0;
    end
  end

  // Clearing pass over the history memory after reset
  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_active_d = 1'b0;
      end
    end
  end

  // Stage B: select coefficients, form the five rounded products
  logic signed [DATA_W-1:0] b_f1, b_f2, b_s1, b_s2, b_c1, b_c2, b_c3, b_scale;
  logic signed [PROD_W-1:0] b_p0, b_p1, b_p2, b_p3, b_p4;

  always_comb begin
    b_f1    = rd_q[4*DATA_W-1:3*DATA_W];
    b_f2    = rd_q[3*DATA_W-1:2*DATA_W];
    b_s1    = rd_q[2*DATA_W-1:DATA_W];
    b_s2    = rd_q[DATA_W-1:0];
    b_c1    = b_in_q ? coef_one_q   : '0;
    b_c2    = b_in_q ? coef_two_q   : '0;
    b_c3    = b_in_q ? coef_three_q : '0;
    b_scale = (b_cmd_q == CMD_EY) ? elec_scale_q : mag_scale_q;
    b_p0    = b_scale * b_flux_q;
    b_p1    = b_c1 * b_f1;
    b_p2    = b_c1 * b_f2;
    b_p3    = b_c2 * b_s1;
    b_p4    = b_c3 * b_s2;
  end

  // Stage C: sum the numerator and the shared history terms
  logic signed [ACC_W-1:0] c_acc, c_sum;

  always_comb begin
    c_sum = (ACC_W'(c_t1_q) + ACC_W'(c_t1_q)) + ACC_W'(c_t2_q) -
            ACC_W'(c_t3_q) - ACC_W'(c_t4_q);
    c_acc = ACC_W'(c_t0_q) - (ACC_W'(c_t1_q) + ACC_W'(c_t1_q)) - ACC_W'(c_t2_q) +
            ACC_W'(c_t3_q) + ACC_W'(c_t4_q);
  end

  // Stage D: scale the numerator by 1/(1+C1)
  logic signed [DATA_W-1:0] d_r;
  logic signed [PROD_W-1:0] d_prod;
  logic signed [ACC_W-1:0]  d_ext;

  always_comb begin
    d_r    = d_in_q ? recip_q : ONE_Q24;
    d_prod = d_num_q * d_r;
    d_ext  = ACC_W'(q_round(d_prod));
  end

  // Stage E: C1 times the new field
  logic signed [DATA_W-1:0] e_c1;
  logic signed [PROD_W-1:0] e_prod;

  always_comb begin
    e_c1   = e_in_q ? coef_one_q : '0;
    e_prod = e_c1 * e_fnew_q;
  end

  // Stage F: new auxiliary value and write-back word
  logic signed [ACC_W-1:0]  f_acc;
  logic signed [DATA_W-1:0] f_aux;
  logic                     mem_we;
  logic [AW-1:0]            mem_wa;
  logic [HIST_W-1:0]        mem_wd;

  always_comb begin
    f_acc  = ACC_W'(f_p_q) + f_sum_q;
    f_aux  = sat32(f_acc);
    mem_we = clr_active_q || f_valid_q;
    mem_wa = clr_active_q ? clr_cnt_q : f_addr_q;
    mem_wd = clr_active_q ? '0 : {f_fnew_q, f_f1_q, f_aux, f_s1_q};
  end

  // History memory: one word per cell, read-first, registered read
  logic [HIST_W-1:0] hist_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    if (a_go) begin
      rd_q <= hist_mem[a_addr_q];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      a_valid_q    <= 1'b0;
      b_valid_q    <= 1'b0;
      c_valid_q    <= 1'b0;
      d_valid_q    <= 1'b0;
      e_valid_q    <= 1'b0;
      f_valid_q    <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      a_valid_q    <= a_valid_d;
      b_valid_q    <= a_go;
      c_valid_q    <= b_valid_q;
      d_valid_q    <= c_valid_q;
      e_valid_q    <= d_valid_q;
      f_valid_q    <= e_valid_q;
      done_q       <= f_valid_q;
    end
  end

  // Payload registers: advance every cycle, stage A holds while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      a_addr_q <= addr_d;
      a_cmd_q  <= cmd_i;
      a_flux_q <= flux_i;
      a_in_q   <= in_slab;
    end
    b_addr_q <= a_addr_q;
    b_cmd_q  <= a_cmd_q;
    b_flux_q <= a_flux_q;
    b_in_q   <= a_in_q;

    c_addr_q <= b_addr_q;
    c_in_q   <= b_in_q;
    c_t0_q   <= q_round(b_p0);
    c_t1_q   <= q_round(b_p1);
    c_t2_q   <= q_round(b_p2);
    c_t3_q   <= q_round(b_p3);
    c_t4_q   <= q_round(b_p4);
    c_f1_q   <= b_f1;
    c_s1_q   <= b_s1;

    d_addr_q <= c_addr_q;
    d_in_q   <= c_in_q;
    d_num_q  <= sat32(c_acc);
    d_sum_q  <= c_sum;
    d_f1_q   <= c_f1_q;
    d_s1_q   <= c_s1_q;

    e_addr_q <= d_addr_q;
    e_in_q   <= d_in_q;
    e_fnew_q <= sat32(d_ext);
    e_sum_q  <= d_sum_q;
    e_f1_q   <= d_f1_q;
    e_s1_q   <= d_s1_q;

    f_addr_q <= e_addr_q;
    f_in_q   <= e_in_q;
    f_p_q    <= q_round(e_prod);
    f_fnew_q <= e_fnew_q;
    f_sum_q  <= e_sum_q;
    f_f1_q   <= e_f1_q;
    f_s1_q   <= e_s1_q;

    field_q  <= f_fnew_q;
    aux_q    <= f_aux;
    inside_q <= f_in_q;
  end

  assign done_o        = done_q;
  assign field_value_o = field_q;
  assign aux_value_o   = aux_q;
  assign inside_slab_o = inside_q;

  // Every read that issues ends in a result strobe after stages B to F
  assert property (@(posedge clk_i) disable iff (!rst_ni) a_go |=> ##5 done_q)
    else $error("issued read did not produce a result");

  // A read in stage B never shares its address with a write-back in stage F
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && f_valid_q) |-> (b_addr_q != f_addr_q))
    else $error("read overlaps pending write-back of the same entry");

  // The clearing pass owns the write port alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !(a_valid_q || b_valid_q || f_valid_q))
    else $error("command in flight during clearing pass");

endmodule
